@@ sv/fski_pkg.sv @@
// Package for the first-seen key indexer: request and result words,
// request and status codes, and the control word broadcast to the cells.
// No dependencies.
package fski_pkg;

  // Default number of cells in the key table.
  localparam int TableDepthDefault = 64;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_CLASSIFY = 2'd0,
    REQ_START    = 2'd1,
    REQ_NEXT     = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_type_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_FULL      = 3'd3,
    ST_COUNT     = 3'd4,
    ST_ENTRY     = 3'd5,
    ST_NONE      = 3'd6,
    ST_CLEARED   = 3'd7
  } status_t;

  // Input word.
  typedef struct packed {
    req_type_t   req_type;
    logic [15:0] key_value;
    logic        malformed;
  } request_t;

  // Output word.
  typedef struct packed {
    status_t     status;
    logic [5:0]  entry_index;
    logic [15:0] entry_value;
    logic [6:0]  entry_count;
  } result_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic        find_key;  // 1: match on key, 0: match on the readout cursor
    logic        wr_en;     // store key into the cell selected by the write index
    logic [15:0] key;
  } cell_ctrl_t;

endpackage

@@ sv/first_seen_key_indexer.sv @@
// A lookup or a readout step that walks the chain strobes its result once the
// search word has passed every cell; start readout, clear, refused items and
// readout steps with no entry left strobe straight from the evaluate state.
// One item at a time: the next word is taken in the strobe cycle, and the search
// word passes one cell per cycle. Reset clears the count and cursor; stored keys
// are kept and only read below the count.
module first_seen_key_indexer #(
  parameter int TABLE_DEPTH = fski_pkg::TableDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  fski_pkg::request_t req,
  output logic               done,
  output fski_pkg::result_t  result
);
  import fski_pkg::*;

  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CntW-1:0] FullCnt = CntW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_WALK = 3'b100
  } state_t;

  state_t          state, state_next;
  request_t        req_q;
  logic [CntW-1:0] used_count, used_count_next;
  logic [CntW-1:0] read_cursor, read_cursor_next;
  result_t         result_next;

  logic            accept, launch, finish_direct, finish_walk, insert;
  cell_ctrl_t      ctrl;
  status_t         status_sel;
  logic [IdxW-1:0] idx_sel;
  logic [15:0]     value_sel;
  logic [IdxW+5:0] idx_wide;
  logic [CntW+6:0] cnt_wide;

  logic            tok_valid [TABLE_DEPTH+1];
  logic            tok_hit   [TABLE_DEPTH+1];
  logic [IdxW-1:0] tok_idx   [TABLE_DEPTH+1];
  logic [15:0]     tok_value [TABLE_DEPTH+1];

  // Handshake and sequencing decisions.
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign launch = (state == S_EVAL) &&
                  (((req_q.req_type == REQ_CLASSIFY) && !req_q.malformed) ||
                   ((req_q.req_type == REQ_NEXT) && (read_cursor < used_count)));
  assign finish_direct = (state == S_EVAL) && !launch;
  assign finish_walk   = (state == S_WALK) && tok_valid[TABLE_DEPTH];
  assign insert = finish_walk && ctrl.find_key && !tok_hit[TABLE_DEPTH] &&
                  (used_count != FullCnt);

  // Broadcast to the cells.
  assign ctrl.find_key = (req_q.req_type == REQ_CLASSIFY);
  assign ctrl.wr_en    = insert;
  assign ctrl.key      = req_q.key_value;

  // Head of the chain.
  assign tok_valid[0] = launch;
  assign tok_hit[0]   = 1'b0;
  assign tok_idx[0]   = '0;
  assign tok_value[0] = '0;

  // The row of cells.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    fski_cell #(
      .CntW (CntW),
      .IdxW (IdxW),
      .Idx  (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .count     (used_count),
      .cursor    (read_cursor),
      .wr_idx    (used_count[IdxW-1:0]),
      .in_valid  (tok_valid[g]),
      .in_hit    (tok_hit[g]),
      .in_idx    (tok_idx[g]),
      .in_value  (tok_value[g]),
      .out_valid (tok_valid[g+1]),
      .out_hit   (tok_hit[g+1]),
      .out_idx   (tok_idx[g+1]),
      .out_value (tok_value[g+1])
    );
  end

  // Result word and state updates for a finishing item.
  always_comb begin
    status_sel       = ST_NONE;
    idx_sel          = '0;
    value_sel        = '0;
    used_count_next  = used_count;
    read_cursor_next = read_cursor;
    if (finish_direct) begin
      case (req_q.req_type)
        REQ_CLASSIFY: begin
          status_sel = ST_MALFORMED;
        end
        REQ_START: begin
          if (used_count != '0) begin
            status_sel       = ST_COUNT;
            read_cursor_next = '0;
          end
        end
        REQ_CLEAR: begin
          status_sel      = ST_CLEARED;
          used_count_next = '0;
        end
        default: begin
          status_sel = ST_NONE;
        end
      endcase
    end else if (finish_walk) begin
      if (ctrl.find_key) begin
        if (tok_hit[TABLE_DEPTH]) begin
          status_sel = ST_HIT;
          idx_sel    = tok_idx[TABLE_DEPTH];
          value_sel  = tok_value[TABLE_DEPTH];
        end else if (used_count == FullCnt) begin
          status_sel = ST_FULL;
        end else begin
          status_sel      = ST_INSERTED;
          idx_sel         = used_count[IdxW-1:0];
          value_sel       = req_q.key_value;
          used_count_next = CntW'(used_count + 1'b1);
        end
      end else begin
        status_sel       = ST_ENTRY;
        idx_sel          = tok_idx[TABLE_DEPTH];
        value_sel        = tok_value[TABLE_DEPTH];
        read_cursor_next = CntW'(read_cursor + 1'b1);
      end
    end
  end

  // Output fields are the low bits of the index and count.
  assign idx_wide = {6'b0, idx_sel};
  assign cnt_wide = {7'b0, used_count_next};
  assign result_next.status      = status_sel;
  assign result_next.entry_index = idx_wide[5:0];
  assign result_next.entry_value = value_sel;
  assign result_next.entry_count = cnt_wide[6:0];

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = launch ? S_WALK : S_IDLE;
      end
      S_WALK: begin
        if (tok_valid[TABLE_DEPTH]) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      used_count  <= '0;
      read_cursor <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      used_count  <= used_count_next;
      read_cursor <= read_cursor_next;
      done        <= finish_direct || finish_walk;
    end
  end

  // Request capture and result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (finish_direct || finish_walk) begin
      result <= result_next;
    end
  end

endmodule

@@ sv/fski_cell.sv @@
// One cell of the key table chain: holds one stored key and passes the
// search word on to its right-hand neighbor every cycle.
// Depends on fski_pkg.
module fski_cell #(
  parameter int CntW = 7,
  parameter int IdxW = 6,
  parameter int Idx  = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  fski_pkg::cell_ctrl_t ctrl,
  input  logic [CntW-1:0]     count,
  input  logic [CntW-1:0]     cursor,
  input  logic [IdxW-1:0]     wr_idx,
  input  logic                in_valid,
  input  logic                in_hit,
  input  logic [IdxW-1:0]     in_idx,
  input  logic [15:0]         in_value,
  output logic                out_valid,
  output logic                out_hit,
  output logic [IdxW-1:0]     out_idx,
  output logic [15:0]         out_value
);
  import fski_pkg::*;

  localparam logic [CntW-1:0] MyCnt = CntW'(Idx);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic [15:0] stored;
  logic        match;

  // Stored key; written only on an insert aimed at this cell.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (wr_idx == MyIdx)) begin
      stored <= ctrl.key;
    end
  end

  // A live cell matches on its key during a lookup, or on its position during readout.
  assign match = (MyCnt < count) &&
                 (ctrl.find_key ? (stored == ctrl.key) : (MyCnt == cursor));

  // The search word advances one cell per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Live keys are distinct, so at most one cell along the chain takes the word.
  always_ff @(posedge clk) begin
    out_hit   <= in_hit | match;
    out_idx   <= match ? MyIdx : in_idx;
    out_value <= match ? stored : in_value;
  end

endmodule

@@ sv/fski_checker.sv @@
// Port-level checks for the first-seen key indexer, and the bind that
// attaches them to the top level. Depends on fski_pkg.
module fski_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input fski_pkg::result_t result
);
  import fski_pkg::*;

  // An accepted word keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // A result strobe comes only when the block is ready again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // One result per word, never two strobes in a row.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // A clear leaves the table empty.
  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_CLEARED)) |-> (result.entry_count == 7'd0))
    else $error("clear did not empty the table");

  // A new key gets the last index of the grown table.
  a_insert_index: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_INSERTED)) |->
      (result.entry_index == 6'(result.entry_count - 7'd1)))
    else $error("inserted index does not follow the count");

endmodule

bind first_seen_key_indexer fski_checker u_fski_checker (.*);

@@ bench/tb_first_seen_key_indexer.sv @@
// Self-checking bench for first_seen_key_indexer: directed and random request words,
// with an in-bench key table model and a result checker.
// Depends on fski_pkg and the first_seen_key_indexer RTL.
`timescale 1ns / 100ps

module tb_first_seen_key_indexer;
  import fski_pkg::*;

  localparam int ChainDepth = TableDepthDefault;
  localparam int RandomWords = 600;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t req;
  logic     done;
  result_t  result;

  // Shadow copy of the key table, entry count and readout cursor.
  logic [15:0] shadow_keys [ChainDepth];
  int          shadow_count;
  int          shadow_cursor;

  // Answers awaited from the block, oldest first.
  result_t     pending_answers [$];

  int  accepted_words;
  int  checked_answers;
  int  mismatch_count;
  int  status_seen [8];
  bit  no_idle_stretch;

  first_seen_key_indexer #(
    .TABLE_DEPTH(ChainDepth)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .result(result)
  );

  // Free-running clock, 20 ns period.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Work out the answer to one accepted word and update the shadow state.
  function automatic result_t compute_answer(input request_t w);
    result_t a;
    bit      found;
    int      slot;
    a = '0;
    found = 1'b0;
    slot = 0;
    case (w.req_type)
      REQ_CLASSIFY: begin
        if (w.malformed) begin
          a.status = ST_MALFORMED;
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            if (!found && shadow_keys[i] == w.key_value) begin
              found = 1'b1;
              slot = i;
            end
          end
          if (found) begin
            a.status = ST_HIT;
            a.entry_index = 6'(slot);
            a.entry_value = w.key_value;
          end else if (shadow_count >= ChainDepth) begin
            a.status = ST_FULL;
          end else begin
            shadow_keys[shadow_count] = w.key_value;
            a.status = ST_INSERTED;
            a.entry_index = 6'(shadow_count);
            a.entry_value = w.key_value;
            shadow_count++;
          end
        end
      end
      REQ_START: begin
        if (shadow_count == 0) begin
          a.status = ST_NONE;
        end else begin
          shadow_cursor = 0;
          a.status = ST_COUNT;
        end
      end
      REQ_NEXT: begin
        if (shadow_cursor >= shadow_count || shadow_cursor >= ChainDepth) begin
          a.status = ST_NONE;
        end else begin
          a.status = ST_ENTRY;
          a.entry_index = 6'(shadow_cursor);
          a.entry_value = shadow_keys[shadow_cursor];
          shadow_cursor++;
        end
      end
      default: begin
        // Clear drops the count only; keys and cursor stay.
        shadow_count = 0;
        a.status = ST_CLEARED;
      end
    endcase
    a.entry_count = 7'(shadow_count);
    return a;
  endfunction

  function automatic request_t make_word(input req_type_t t, input logic [15:0] k,
                                         input logic bad);
    request_t w;
    w.req_type = t;
    w.key_value = k;
    w.malformed = bad;
    return w;
  endfunction

  // Sender idle time: mostly none or short, sometimes long enough to span the chain.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle_stretch || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    return $urandom_range(5, ChainDepth + 16);
  endfunction

  // Offer one word, wait for it to be taken, record its answer, then idle for a random gap, which may be none.
  task automatic send_word(input request_t w);
    int gap;
    start <= 1'b1;
    req <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_answers.push_back(compute_answer(w));
    accepted_words++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Compare every strobed result with the oldest awaited answer.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result status=%0d index=%0d value=%h count=%0d",
                   $realtime, result.status, result.entry_index, result.entry_value,
                   result.entry_count);
      end else begin
        want = pending_answers.pop_front();
        checked_answers++;
        status_seen[want.status]++;
        if (result.status !== want.status || result.entry_index !== want.entry_index ||
            result.entry_value !== want.entry_value ||
            result.entry_count !== want.entry_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch: expected status=%0d index=%0d value=%h count=%0d, %s",
                     $realtime, want.status, want.entry_index, want.entry_value,
                     want.entry_count,
                     $sformatf("got status=%0d index=%0d value=%h count=%0d",
                               result.status, result.entry_index, result.entry_value,
                               result.entry_count));
        end
      end
    end
  end

  // Empty-table answers, key extremes, refused words and a cursor left past the count.
  task automatic test_empty_and_extremes();
    send_word(make_word(REQ_NEXT, 16'h0000, 1'b0));
    send_word(make_word(REQ_START, 16'h0000, 1'b0));
    send_word(make_word(REQ_CLEAR, 16'hFFFF, 1'b0));
    send_word(make_word(REQ_CLASSIFY, 16'h0000, 1'b1));
    send_word(make_word(REQ_CLASSIFY, 16'h0000, 1'b0));
    send_word(make_word(REQ_CLASSIFY, 16'hFFFF, 1'b0));
    send_word(make_word(REQ_CLASSIFY, 16'h0000, 1'b0));
    send_word(make_word(REQ_CLASSIFY, 16'hFFFF, 1'b1));
    send_word(make_word(REQ_CLASSIFY, 16'hFFFF, 1'b0));
    // The malformed bit must be ignored outside classify.
    send_word(make_word(REQ_START, 16'hFFFF, 1'b1));
    send_word(make_word(REQ_NEXT, 16'hFFFF, 1'b1));
    send_word(make_word(REQ_NEXT, 16'h0000, 1'b0));
    send_word(make_word(REQ_NEXT, 16'h0000, 1'b0));
    send_word(make_word(REQ_CLEAR, 16'h0000, 1'b1));
    // Cursor now sits beyond the count.
    send_word(make_word(REQ_NEXT, 16'h0000, 1'b0));
    send_word(make_word(REQ_CLASSIFY, 16'h1234, 1'b0));
    send_word(make_word(REQ_NEXT, 16'h0000, 1'b0));
    send_word(make_word(REQ_CLASSIFY, 16'hA5A5, 1'b0));
    send_word(make_word(REQ_CLASSIFY, 16'h5A5A, 1'b0));
    send_word(make_word(REQ_NEXT, 16'h0000, 1'b0));
    send_word(make_word(REQ_NEXT, 16'h0000, 1'b0));
  endtask

  // Fill every cell, then probe a full table and read all entries out.
  task automatic test_full_table();
    logic [9:0] tags [ChainDepth];
    send_word(make_word(REQ_CLEAR, 16'h0000, 1'b0));
    // Low bits hold the slot number, so all keys differ.
    for (int i = 0; i < ChainDepth; i++) begin
      tags[i] = 10'($urandom);
      send_word(make_word(REQ_CLASSIFY, {tags[i], 6'(i)}, 1'b0));
    end
    send_word(make_word(REQ_CLASSIFY, {~tags[5], 6'd5}, 1'b0));
    send_word(make_word(REQ_CLASSIFY, {tags[ChainDepth-1], 6'(ChainDepth-1)}, 1'b0));
    send_word(make_word(REQ_CLASSIFY, {tags[0], 6'd0}, 1'b0));
    send_word(make_word(REQ_CLASSIFY, 16'($urandom), 1'b1));
    send_word(make_word(REQ_START, 16'($urandom), 1'b0));
    for (int i = 0; i <= ChainDepth; i++)
      send_word(make_word(REQ_NEXT, 16'($urandom), 1'($urandom)));
    send_word(make_word(REQ_CLEAR, 16'h0000, 1'b0));
  endtask

  // Random traffic: mostly classify from a shared key set, readout walks, clears, noise.
  task automatic test_random_traffic();
    logic [15:0] key_set [72];
    int          first_word;
    int          roll;
    int          steps;
    request_t    w;
    foreach (key_set[i]) key_set[i] = 16'($urandom);
    first_word = accepted_words;
    while (accepted_words - first_word < RandomWords) begin
      no_idle_stretch = (((accepted_words - first_word) / 60) % 3) == 1;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        send_word(make_word(REQ_START, 16'($urandom), 1'($urandom)));
        steps = $urandom_range(0, shadow_count + 2);
        repeat (steps) send_word(make_word(REQ_NEXT, 16'($urandom), 1'($urandom)));
      end else if (roll < 8) begin
        send_word(make_word(REQ_CLEAR, 16'($urandom), 1'($urandom)));
      end else if (roll < 16) begin
        w.req_type = req_type_t'($urandom_range(0, 3));
        w.key_value = 16'($urandom);
        w.malformed = 1'($urandom);
        send_word(w);
      end else begin
        w.req_type = REQ_CLASSIFY;
        w.key_value = ($urandom_range(0, 9) < 8) ? key_set[$urandom_range(0, 71)]
                                                 : 16'($urandom);
        w.malformed = ($urandom_range(0, 99) < 8);
        send_word(w);
      end
    end
    no_idle_stretch = 1'b0;
  endtask

  // Overall time limit.
  initial begin
    #20_000_000;
    $display("tb_first_seen_key_indexer: FAIL");
    $finish;
  end

  // Main sequence: reset, tests in turn, drain, verdict.
  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    shadow_count = 0;
    shadow_cursor = 0;
    accepted_words = 0;
    checked_answers = 0;
    mismatch_count = 0;
    no_idle_stretch = 1'b0;
    foreach (shadow_keys[i]) shadow_keys[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_extremes();
    test_full_table();
    test_random_traffic();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (ChainDepth + 4) @(posedge clk);
    $display("Checked %0d of %0d words: %0d hit, %0d inserted, %0d refused, %0d full,",
             checked_answers, accepted_words, status_seen[ST_HIT], status_seen[ST_INSERTED],
             status_seen[ST_MALFORMED], status_seen[ST_FULL]);
    $display("  %0d readout starts, %0d entries read, %0d empty answers, %0d clears.",
             status_seen[ST_COUNT], status_seen[ST_ENTRY], status_seen[ST_NONE],
             status_seen[ST_CLEARED]);
    if (mismatch_count == 0) begin
      $display("tb_first_seen_key_indexer: PASS");
    end else begin
      $display("%0d mismatches in total.", mismatch_count);
      $display("tb_first_seen_key_indexer: FAIL");
    end
    $finish;
  end

endmodule
